// ----- rtl/rv32_rtype_alu_execute_top_defines.svh -----
// Assertion macros shared by the execute block modules.
`ifndef RV32_RTYPE_ALU_EXECUTE_TOP_DEFINES_SVH
`define RV32_RTYPE_ALU_EXECUTE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RV32ALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RV32ALU_NEVER(lbl, expr, msg) \
  `RV32ALU_ASSERT(lbl, !(expr), msg)
`else
`define RV32ALU_ASSERT(lbl, prop, msg)
`define RV32ALU_NEVER(lbl, expr, msg)
`endif

`endif

// ----- rtl/rv32alu_pkg.sv -----
// Types and constants of the R-type ALU execute block.
package rv32alu_pkg;

  localparam int unsigned XLEN        = 32;
  localparam int unsigned NUM_REGS    = 32;
  localparam int unsigned REG_IDX_W   = 5;
  localparam int unsigned SHAMT_W     = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_X0     = 2'd1,
    ST_BAD_F7 = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD,
    OP_SUB,
    OP_SLL,
    OP_SLT,
    OP_SLTU,
    OP_XOR,
    OP_SRL,
    OP_SRA,
    OP_OR,
    OP_AND
  } op_e;

  typedef struct packed {
    logic                 kind;
    logic [XLEN-1:0]      instruction;
    logic [REG_IDX_W-1:0] load_index;
    logic [XLEN-1:0]      load_value;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [REG_IDX_W-1:0] dest_index;
    logic [XLEN-1:0]      dest_value;
    logic                 wrote;
    logic [XLEN-1:0]      src1_value;
    logic [XLEN-1:0]      src2_value;
  } out_item_t;

  typedef struct packed {
    op_e                  op;
    status_e              status;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rs1;
    logic [REG_IDX_W-1:0] rs2;
    logic [XLEN-1:0]      load_value;
  } uop_t;

  typedef struct packed {
    logic valid;
    uop_t uop;
  } uop_req_t;

endpackage

// ----- rtl/rv32alu_ram.sv -----
// Generic single-write, registered-read RAM.
module rv32alu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/rv32alu_front.sv -----
// Front end: decode and classify incoming items into micro-ops.
module rv32alu_front (
  input  rv32alu_pkg::in_item_t in_data_i,
  input  logic                  in_valid_i,
  output rv32alu_pkg::uop_req_t req_o
);
  import rv32alu_pkg::*;

  logic [REG_IDX_W-1:0] rd;
  logic [2:0]           f3;
  logic [6:0]           f7;
  uop_t                 uop;

  assign rd = in_data_i.instruction[11:7];
  assign f3 = in_data_i.instruction[14:12];
  assign f7 = in_data_i.instruction[31:25];

  always_comb begin
    uop            = '0;
    uop.load_value = in_data_i.load_value;
    uop.status     = ST_DONE;
    uop.op         = OP_NONE;
    if (in_data_i.kind) begin
      uop.rd = in_data_i.load_index;
      if (in_data_i.load_index == '0) begin
        uop.status = ST_X0;
      end else begin
        uop.op = OP_LOAD;
      end
    end else begin
      uop.rd  = rd;
      uop.rs1 = in_data_i.instruction[19:15];
      uop.rs2 = in_data_i.instruction[24:20];
      if (rd == '0) begin
        uop.status = ST_X0;
      end else if (f7 == F7_BASE) begin
        case (f3)
          F3_ADD:  uop.op = OP_ADD;
          F3_SLL:  uop.op = OP_SLL;
          F3_SLT:  uop.op = OP_SLT;
          F3_SLTU: uop.op = OP_SLTU;
          F3_XOR:  uop.op = OP_XOR;
          F3_SR:   uop.op = OP_SRL;
          F3_OR:   uop.op = OP_OR;
          default: uop.op = OP_AND;
        endcase
      end else if (f7 == F7_ALT && f3 == F3_ADD) begin
        uop.op = OP_SUB;
      end else if (f7 == F7_ALT && f3 == F3_SR) begin
        uop.op = OP_SRA;
      end else begin
        uop.status = ST_BAD_F7;
      end
    end
  end

  assign req_o.valid = in_valid_i;
  assign req_o.uop   = uop;
endmodule

// ----- rtl/rv32alu_fifo.sv -----
// Micro-op queue between front end and back end.
`include "rv32_rtype_alu_execute_top_defines.svh"
module rv32alu_fifo #(
  parameter int unsigned Depth = rv32alu_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rv32alu_pkg::uop_req_t push_i,
  output logic                  push_ready_o,
  output rv32alu_pkg::uop_req_t pop_o,
  input  logic                  pop_ready_i
);
  import rv32alu_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  uop_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full, empty, push, pop;

  assign full         = (cnt_q == CntW'(Depth));
  assign empty        = (cnt_q == '0);
  assign push_ready_o = !full;
  assign push         = push_i.valid && !full;
  assign pop          = pop_ready_i && !empty;

  assign pop_o.valid = !empty;
  assign pop_o.uop   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.uop;
    end
  end

  `RV32ALU_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count out of range")
  `RV32ALU_ASSERT(a_cnt_step, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1),
                  "queue count did not advance on push")
  `RV32ALU_NEVER(a_ptr_mismatch, empty && (wr_ptr_q != rd_ptr_q), "empty queue pointers differ")
endmodule

// ----- rtl/rv32alu_back.sv -----
// Back end: register file read, ALU, write back and output register.
`include "rv32_rtype_alu_execute_top_defines.svh"
module rv32alu_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rv32alu_pkg::uop_req_t  req_i,
  output logic                   req_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rv32alu_pkg::out_item_t out_data_o
);
  import rv32alu_pkg::*;

  logic                 x2_valid_q;
  uop_t                 x2_uop_q;
  logic                 v1_q, v2_q, vd_q;
  logic [NUM_REGS-1:0]  valid_q;
  logic                 wr_seen_q;
  logic [REG_IDX_W-1:0] wr_addr_q;
  logic [XLEN-1:0]      wr_data_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic                 pop, x2_adv, we;
  logic [XLEN-1:0]      ram1, ram2, ramd;
  logic [XLEN-1:0]      src1, src2, srcd, res;
  logic [SHAMT_W-1:0]   sh;
  logic                 do_write;
  out_item_t            out_d;

  assign x2_adv      = x2_valid_q && (!out_valid_q || out_ready_i);
  assign req_ready_o = !x2_valid_q || x2_adv;
  assign pop         = req_i.valid && req_ready_o;
  assign do_write    = (x2_uop_q.op != OP_NONE);
  assign we          = x2_adv && do_write;

  rv32alu_ram #(.Width(XLEN), .Depth(NUM_REGS)) u_ram_rs1 (
    .clk_i, .we_i(we), .waddr_i(x2_uop_q.rd), .wdata_i(res),
    .re_i(pop), .raddr_i(req_i.uop.rs1), .rdata_o(ram1)
  );
  rv32alu_ram #(.Width(XLEN), .Depth(NUM_REGS)) u_ram_rs2 (
    .clk_i, .we_i(we), .waddr_i(x2_uop_q.rd), .wdata_i(res),
    .re_i(pop), .raddr_i(req_i.uop.rs2), .rdata_o(ram2)
  );
  rv32alu_ram #(.Width(XLEN), .Depth(NUM_REGS)) u_ram_rd (
    .clk_i, .we_i(we), .waddr_i(x2_uop_q.rd), .wdata_i(res),
    .re_i(pop), .raddr_i(req_i.uop.rd), .rdata_o(ramd)
  );

  // Bypass the most recent write; unwritten entries read as zero.
  assign src1 = (wr_seen_q && wr_addr_q == x2_uop_q.rs1) ? wr_data_q :
                (v1_q ? ram1 : '0);
  assign src2 = (wr_seen_q && wr_addr_q == x2_uop_q.rs2) ? wr_data_q :
                (v2_q ? ram2 : '0);
  assign srcd = (wr_seen_q && wr_addr_q == x2_uop_q.rd) ? wr_data_q :
                (vd_q ? ramd : '0);
  assign sh   = src2[SHAMT_W-1:0];

  always_comb begin
    case (x2_uop_q.op)
      OP_LOAD: res = x2_uop_q.load_value;
      OP_ADD:  res = src1 + src2;
      OP_SUB:  res = src1 - src2;
      OP_SLL:  res = src1 << sh;
      OP_SLT:  res = XLEN'($signed(src1) < $signed(src2));
      OP_SLTU: res = XLEN'(src1 < src2);
      OP_XOR:  res = src1 ^ src2;
      OP_SRL:  res = src1 >> sh;
      OP_SRA:  res = $unsigned($signed(src1) >>> sh);
      OP_OR:   res = src1 | src2;
      OP_AND:  res = src1 & src2;
      default: res = '0;
    endcase
  end

  always_comb begin
    out_d.status     = x2_uop_q.status;
    out_d.dest_index = x2_uop_q.rd;
    out_d.dest_value = do_write ? res : srcd;
    out_d.wrote      = do_write;
    out_d.src1_value = src1;
    out_d.src2_value = src2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x2_valid_q  <= 1'b0;
      valid_q     <= '0;
      wr_seen_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        x2_valid_q <= 1'b1;
      end else if (x2_adv) begin
        x2_valid_q <= 1'b0;
      end
      if (we) begin
        valid_q[x2_uop_q.rd] <= 1'b1;
        wr_seen_q            <= 1'b1;
      end
      if (x2_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      x2_uop_q <= req_i.uop;
      v1_q     <= valid_q[req_i.uop.rs1];
      v2_q     <= valid_q[req_i.uop.rs2];
      vd_q     <= valid_q[req_i.uop.rd];
    end
    if (we) begin
      wr_addr_q <= x2_uop_q.rd;
      wr_data_q <= res;
    end
    if (x2_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RV32ALU_NEVER(a_no_x0_write, we && (x2_uop_q.rd == '0), "write to register zero")
  `RV32ALU_ASSERT(a_adv_fills_out, x2_adv |=> out_valid_q, "advanced item not in output register")
  `RV32ALU_ASSERT(a_wrote_done, out_valid_q |-> (!out_q.wrote || out_q.status == ST_DONE),
                  "write reported with failing status")
endmodule

// ----- rtl/rv32_rtype_alu_execute_top.sv -----
// Top level of the RV32I R-type ALU execute block with its register file.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one item per
// cycle while in_ready_o is high: kind 0 executes the R-type word in
// instruction, kind 1 writes load_value into register load_index. Output
// channel (out_valid_o / out_ready_i / out_data_o) returns one result item
// per input item, in order, with status, destination index and value, a
// write flag and both source values. When nothing stalls, an item is
// decoded into the micro-op queue at acceptance, reads the register file
// as it leaves the queue, then passes ALU, write back and output register.
// Each register file copy has a single write port, and a one-deep bypass
// forwards the last write into the read stage.
// Reset clears the register file to zero at once through per-entry valid
// bits; x0 always reads zero. When the receiver stalls the result holds in
// the output register, the read stage holds behind it and the queue fills;
// in_ready_o drops once the queue is full.
module rv32_rtype_alu_execute_top #(
  parameter int unsigned QueueDepth = rv32alu_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rv32alu_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rv32alu_pkg::out_item_t out_data_o
);
  import rv32alu_pkg::*;

  uop_req_t front_req;
  uop_req_t queue_req;
  logic     back_ready;

  rv32alu_front u_front (
    .in_data_i (in_data_i),
    .in_valid_i(in_valid_i),
    .req_o     (front_req)
  );

  rv32alu_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (front_req),
    .push_ready_o(in_ready_o),
    .pop_o       (queue_req),
    .pop_ready_i (back_ready)
  );

  rv32alu_back u_back (
    .clk_i,
    .rst_ni,
    .req_i      (queue_req),
    .req_ready_o(back_ready),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );
endmodule

// ----- test/tb_rv32_rtype_alu_execute_top.sv -----
// Self-checking testbench for the R-type ALU execute block with its register file.
module tb_rv32_rtype_alu_execute_top;
  import rv32alu_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned ITEMS_PER_PHASE = 240;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [XLEN-1:0] arch_regs [NUM_REGS];
  in_item_t        instr_stream [$];
  out_item_t       retire_queue [$];
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     hold_requests = 0;
  int unsigned     hold_served = 0;
  int unsigned     hold_left = 0;
  int unsigned     stall_cycles = 0;
  int unsigned     errors = 0;

  rv32_rtype_alu_execute_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < NUM_REGS; i++) begin
      arch_regs[i] = '0;
    end
  end

  function automatic out_item_t retire_item(input in_item_t it);
    out_item_t       res;
    logic [4:0]      rd;
    logic [4:0]      rs1;
    logic [4:0]      rs2;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [4:0]      sh;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] v;
    logic            ok;
    res = '0;
    res.status = ST_DONE;
    if (it.kind) begin
      res.dest_index = it.load_index;
      if (it.load_index == '0) begin
        res.status = ST_X0;
      end else begin
        arch_regs[it.load_index] = it.load_value;
        res.wrote = 1'b1;
      end
      res.dest_value = arch_regs[it.load_index];
      return res;
    end
    rd  = it.instruction[11:7];
    f3  = it.instruction[14:12];
    rs1 = it.instruction[19:15];
    rs2 = it.instruction[24:20];
    f7  = it.instruction[31:25];
    a   = arch_regs[rs1];
    b   = arch_regs[rs2];
    sh  = b[SHAMT_W-1:0];
    ok  = 1'b1;
    v   = '0;
    res.dest_index = rd;
    res.src1_value = a;
    res.src2_value = b;
    if (rd == '0) begin
      res.status = ST_X0;
    end else begin
      if (f7 == F7_BASE) begin
        case (f3)
          F3_ADD:  v = a + b;
          F3_SLL:  v = a << sh;
          F3_SLT:  v = {31'b0, $signed(a) < $signed(b)};
          F3_SLTU: v = {31'b0, a < b};
          F3_XOR:  v = a ^ b;
          F3_SR:   v = a >> sh;
          F3_OR:   v = a | b;
          default: v = a & b;
        endcase
      end else if (f7 == F7_ALT && f3 == F3_ADD) begin
        v = a - b;
      end else if (f7 == F7_ALT && f3 == F3_SR) begin
        v = $signed(a) >>> sh;
      end else begin
        ok = 1'b0;
      end
      if (ok) begin
        arch_regs[rd] = v;
        res.wrote = 1'b1;
      end else begin
        res.status = ST_BAD_F7;
      end
    end
    res.dest_value = arch_regs[rd];
    return res;
  endfunction

  function automatic in_item_t make_load(input logic [4:0] idx, input logic [XLEN-1:0] val);
    in_item_t it;
    it.kind        = 1'b1;
    it.instruction = $urandom;
    it.load_index  = idx;
    it.load_value  = val;
    return it;
  endfunction

  function automatic in_item_t make_rtype(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
    in_item_t it;
    it.kind        = 1'b0;
    it.instruction = {f7, rs2, rs1, f3, rd, 7'($urandom)};
    it.load_index  = 5'($urandom);
    it.load_value  = $urandom;
    return it;
  endfunction

  function automatic logic [XLEN-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'($urandom_range(40));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t pick_item();
    logic [2:0] f3;
    logic [6:0] f7;
    if ($urandom_range(99) < 30) begin
      return make_load(5'($urandom), pick_value());
    end
    f3 = 3'($urandom);
    if ($urandom_range(99) < 10) begin
      f7 = 7'($urandom);
    end else if ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(1) == 1) begin
      f7 = F7_ALT;
    end else begin
      f7 = F7_BASE;
    end
    return make_rtype(f7, 5'($urandom), 5'($urandom), f3, 5'($urandom));
  endfunction

  task automatic check_field(input string name, input logic [XLEN-1:0] exp_v,
                             input logic [XLEN-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h actual %h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic wait_drained();
    while (instr_stream.size() != 0 || in_valid || retire_queue.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        retire_queue.push_back(retire_item(in_data));
      end
      if (!in_valid || in_ready) begin
        if (instr_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= instr_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (retire_queue.size() == 0) begin
        $display("%0t: unexpected result: expected none actual %h", $realtime, out_data);
        errors++;
      end else begin
        out_item_t exp_r;
        exp_r = retire_queue.pop_front();
        check_field("status", 32'(exp_r.status), 32'(out_data.status));
        check_field("dest_index", 32'(exp_r.dest_index), 32'(out_data.dest_index));
        check_field("dest_value", exp_r.dest_value, out_data.dest_value);
        check_field("wrote", 32'(exp_r.wrote), 32'(out_data.wrote));
        check_field("src1_value", exp_r.src1_value, out_data.src1_value);
        check_field("src2_value", exp_r.src2_value, out_data.src2_value);
      end
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, stall_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    instr_stream.push_back(make_load(5'd1, 32'h8000_0000));
    instr_stream.push_back(make_load(5'd2, 32'h7fff_ffff));
    instr_stream.push_back(make_load(5'd3, 32'hffff_ffff));
    instr_stream.push_back(make_load(5'd4, 32'h0000_001f));
    instr_stream.push_back(make_load(5'd0, 32'hdead_beef));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd1, 5'd3, F3_ADD, 5'd5));
    instr_stream.push_back(make_rtype(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd6));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd4, 5'd3, F3_SLL, 5'd7));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd8));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd2, 5'd1, F3_SLTU, 5'd9));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd3, 5'd1, F3_XOR, 5'd10));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd4, 5'd3, F3_SR, 5'd11));
    instr_stream.push_back(make_rtype(F7_ALT, 5'd4, 5'd1, F3_SR, 5'd12));
    instr_stream.push_back(make_rtype(F7_ALT, 5'd3, 5'd2, F3_SR, 5'd13));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd2, 5'd1, F3_OR, 5'd14));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd2, 5'd3, F3_AND, 5'd15));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0));
    instr_stream.push_back(make_rtype(7'h01, 5'd2, 5'd1, F3_ADD, 5'd5));
    instr_stream.push_back(make_rtype(F7_ALT, 5'd4, 5'd3, F3_SLL, 5'd7));
    instr_stream.push_back(make_rtype(7'h7f, 5'd31, 5'd31, F3_AND, 5'd0));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd3, 5'd0, F3_ADD, 5'd31));
    instr_stream.push_back(make_rtype(F7_BASE, 5'd3, 5'd3, F3_SLT, 5'd30));
    instr_stream.push_back(make_rtype(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd29));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 66;
        end
        default: begin
          send_idle_pct = 25;
          recv_idle_pct = 25;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        instr_stream.push_back(pick_item());
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (int i = 0; i < 60; i++) begin
      instr_stream.push_back(pick_item());
    end
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (retire_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, retire_queue.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
